// File: rtl/multi_port_spi_master_sequencer_macros.svh
// Assertion macros shared by the sequencer RTL.
`ifndef MULTI_PORT_SPI_MASTER_SEQUENCER_MACROS_SVH
`define MULTI_PORT_SPI_MASTER_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF
// Property holds at every clock edge outside reset.
`define SPI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// When the antecedent holds, the consequent must hold in the following cycle.
`define SPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SPI_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/mpspi_pkg.sv
package mpspi_pkg;

  // Width of the transmit word field.
  localparam int unsigned TX_W = 32;
  // Number of command bits shifted out before an fpga read samples.
  localparam int unsigned READ_CMD_BITS = 8;
  // Number of pin levels held by the sequencer.
  localparam int unsigned PIN_W = 11;

  // Clocks low, latch enables high, data low.
  localparam logic [PIN_W-1:0] PIN_RESET = 11'b010_0100_0110;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    PORT_CTRL  = 2'd0,
    PORT_CONV  = 2'd1,
    PORT_FPGA1 = 2'd2,
    PORT_FPGA2 = 2'd3
  } port_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_OPEN   = 4'd1,
    PH_PRE1   = 4'd2,
    PH_PRE2   = 4'd3,
    PH_PRE3   = 4'd4,
    PH_PRE4   = 4'd5,
    PH_SETUP  = 4'd6,
    PH_HIGH   = 4'd7,
    PH_LOW    = 4'd8,
    PH_SAMPLE = 4'd9,
    PH_SLOW   = 4'd10,
    PH_CLOSE  = 4'd11,
    PH_TAIL1  = 4'd12,
    PH_TAIL2  = 4'd13,
    PH_TAIL3  = 4'd14,
    PH_TAIL4  = 4'd15
  } phase_e;

  typedef logic [3:0] pin_pos_t;

  // Position of each line set's clock within the pin vector.
  function automatic pin_pos_t clk_pos(input port_e p);
    pin_pos_t r;
    unique case (p)
      PORT_CTRL:  r = 4'd10;
      PORT_CONV:  r = 4'd7;
      PORT_FPGA1: r = 4'd4;
      PORT_FPGA2: r = 4'd3;
      default:    r = 4'd10;
    endcase
    return r;
  endfunction

  function automatic pin_pos_t le_pos(input port_e p);
    pin_pos_t r;
    unique case (p)
      PORT_CTRL:  r = 4'd9;
      PORT_CONV:  r = 4'd6;
      PORT_FPGA1: r = 4'd2;
      PORT_FPGA2: r = 4'd1;
      default:    r = 4'd9;
    endcase
    return r;
  endfunction

  // Both fpga line sets share one data line.
  function automatic pin_pos_t dat_pos(input port_e p);
    pin_pos_t r;
    unique case (p)
      PORT_CTRL:  r = 4'd8;
      PORT_CONV:  r = 4'd5;
      PORT_FPGA1: r = 4'd0;
      PORT_FPGA2: r = 4'd0;
      default:    r = 4'd8;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/multi_port_spi_master_sequencer.sv
// Pin sequencer for four serial line sets (control, converter and two fpga line
// sets), each with clock, latch enable and data. Every input item is either a
// time tick or a start request; the block returns exactly one result item per
// input item, carrying the pin levels after that item plus busy, done, error
// and the received byte. A start shows its first pin group on the start item
// itself; after each group the sequencer waits delay_ticks tick items (zero
// acts as one) before the next group is applied, and the tick that ends the
// last delay reports done with busy low. Data goes out MSB first. The control
// port changes data with its clock low and raises the clock to latch; the
// converter port idles its clock high and latches on the falling edge; the
// fpga line sets frame the data with two dummy clock pulses before and after
// it and leave latch enable low at the end. An fpga read shifts out the top
// eight command bits and then samples miso_level on the ticks that apply a
// sampling group; the low eight sampled bits come back with done. A length
// above MAX_BITS, a read on the control or converter port, or any start while
// busy is rejected with error set and nothing else changes. Rate: one item is
// taken every clock. The whole sequencer step for an item is one pass of
// combinational logic from the state registers into the next state and the
// result register, so each result appears in the cycle after its item is
// accepted; the result register stalls only when the downstream side holds
// ready low, and an item is still taken in that cycle if the waiting result
// leaves. The delay register is written by delay_ticks_we_i and should only
// change while the block is idle.

`include "multi_port_spi_master_sequencer_macros.svh"

module multi_port_spi_master_sequencer
  import mpspi_pkg::*;
#(
  parameter int unsigned MAX_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port for delay_ticks.
  input  logic        delay_ticks_we_i,
  input  logic [7:0]  delay_ticks_i,
  // Input item channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [1:0]  port_i,
  input  logic [31:0] tx_word_i,
  input  logic [7:0]  bit_count_i,
  input  logic        miso_level_i,
  // Result item channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  ctrl_pins_o,
  output logic [2:0]  conv_pins_o,
  output logic [4:0]  fpga_pins_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic        error_o,
  output logic [7:0]  read_byte_o
);

  // Bit counters must hold the full length itself.
  localparam int unsigned LenW = $clog2(MAX_BITS + 1);
  // Bit position width; wide enough to compare against the word width.
  localparam int unsigned PosW = (LenW > 6) ? LenW : 6;

  // Sequencer state.
  logic [7:0]       delay_ticks_q;
  phase_e           phase_q, phase_d;
  logic [LenW-1:0]  bit_index_q, bit_index_d;
  logic [7:0]       delay_count_q, delay_count_d;
  logic [TX_W-1:0]  shift_word_q, shift_word_d;
  logic [7:0]       receive_byte_q, receive_byte_d;
  port_e            active_port_q, active_port_d;
  logic             is_read_q, is_read_d;
  logic [LenW-1:0]  length_held_q, length_held_d;
  logic [PIN_W-1:0] pin_levels_q, pin_levels_d;

  // Result register.
  logic             out_valid_q;
  logic [PIN_W-1:0] out_pins_q;
  logic             out_busy_q, out_done_q, out_err_q;
  logic [7:0]       out_rb_q;

  logic             in_accept;
  logic             done_c, err_c, grp_en;
  logic [7:0]       rb_c;
  logic [7:0]       delay_units;
  phase_e           np;
  logic [LenW-1:0]  nbi, bi_inc;
  logic             fpga_q;

  // Group application helpers.
  logic             fpga_d, idle_lvl, tx_bit;
  logic [PosW-1:0]  tx_pos;
  pin_pos_t         pc, pl, pd;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  assign delay_units = (delay_ticks_q == 8'd0) ? 8'd1 : delay_ticks_q;
  assign fpga_q      = active_port_q[1];
  assign bi_inc      = bit_index_q + LenW'(1);

  // Next phase after a delay expires; some steps also advance the bit index.
  always_comb begin
    np  = PH_IDLE;
    nbi = bit_index_q;
    unique case (phase_q)
      PH_OPEN: begin
        if (fpga_q) begin
          np = PH_PRE1;
        end else begin
          np = (length_held_q != '0) ? PH_SETUP : PH_CLOSE;
        end
      end
      PH_PRE1: np = PH_PRE2;
      PH_PRE2: np = PH_PRE3;
      PH_PRE3: np = PH_PRE4;
      PH_PRE4: np = (length_held_q != '0) ? PH_SETUP : PH_CLOSE;
      PH_SETUP: np = PH_HIGH;
      PH_HIGH: begin
        if (fpga_q && is_read_q) begin
          np = PH_LOW;
        end else begin
          nbi = bi_inc;
          np  = (bi_inc < length_held_q) ? PH_SETUP : PH_CLOSE;
        end
      end
      PH_LOW: begin
        nbi = bi_inc;
        if (bi_inc >= length_held_q) begin
          np = PH_CLOSE;
        end else if (bi_inc < LenW'(READ_CMD_BITS)) begin
          np = PH_SETUP;
        end else begin
          np = PH_SAMPLE;
        end
      end
      PH_SAMPLE: np = PH_SLOW;
      PH_SLOW: begin
        nbi = bi_inc;
        np  = (bi_inc < length_held_q) ? PH_SAMPLE : PH_CLOSE;
      end
      PH_CLOSE: np = fpga_q ? PH_TAIL1 : PH_IDLE;
      PH_TAIL1: np = PH_TAIL2;
      PH_TAIL2: np = PH_TAIL3;
      PH_TAIL3: np = PH_TAIL4;
      default:  np = PH_IDLE;
    endcase
  end

  // One sequencer step per accepted item, then the pin group of the new phase.
  always_comb begin
    phase_d        = phase_q;
    bit_index_d    = bit_index_q;
    delay_count_d  = delay_count_q;
    shift_word_d   = shift_word_q;
    receive_byte_d = receive_byte_q;
    active_port_d  = active_port_q;
    is_read_d      = is_read_q;
    length_held_d  = length_held_q;
    pin_levels_d   = pin_levels_q;
    done_c         = 1'b0;
    err_c          = 1'b0;
    rb_c           = 8'd0;
    grp_en         = 1'b0;

    if (in_accept) begin
      unique case (req_e'(req_type_i))
        REQ_TICK: begin
          if (phase_q != PH_IDLE) begin
            if (delay_count_q > 8'd1) begin
              delay_count_d = delay_count_q - 8'd1;
            end else begin
              phase_d     = np;
              bit_index_d = nbi;
              if (np == PH_IDLE) begin
                done_c        = 1'b1;
                rb_c          = is_read_q ? receive_byte_q : 8'd0;
                delay_count_d = 8'd0;
              end else begin
                grp_en        = 1'b1;
                delay_count_d = delay_units;
              end
            end
          end
        end
        REQ_WRITE, REQ_READ: begin
          if ((phase_q != PH_IDLE) || ({1'b0, bit_count_i} > 9'(MAX_BITS)) ||
              ((req_e'(req_type_i) == REQ_READ) && !port_i[1])) begin
            err_c = 1'b1;
          end else begin
            active_port_d  = port_e'(port_i);
            is_read_d      = (req_e'(req_type_i) == REQ_READ);
            length_held_d  = LenW'(bit_count_i);
            shift_word_d   = tx_word_i;
            bit_index_d    = '0;
            receive_byte_d = 8'd0;
            phase_d        = PH_OPEN;
            grp_en         = 1'b1;
            delay_count_d  = delay_units;
          end
        end
        default: begin
        end
      endcase
    end

    // Pin group for the phase just entered, using the updated state.
    fpga_d   = active_port_d[1];
    idle_lvl = (active_port_d == PORT_CONV);
    pc       = clk_pos(active_port_d);
    pl       = le_pos(active_port_d);
    pd       = dat_pos(active_port_d);
    tx_pos   = PosW'(length_held_d) - PosW'(bit_index_d) - PosW'(1);
    tx_bit   = (tx_pos < PosW'(TX_W)) ? shift_word_d[tx_pos[4:0]] : 1'b0;

    if (grp_en) begin
      unique case (phase_d)
        PH_OPEN: pin_levels_d[pl] = 1'b1;
        PH_PRE1, PH_PRE3, PH_TAIL1, PH_TAIL3: pin_levels_d[pc] = 1'b1;
        PH_PRE2, PH_PRE4, PH_TAIL2, PH_TAIL4: pin_levels_d[pc] = 1'b0;
        PH_SETUP: begin
          pin_levels_d[pd] = tx_bit;
          if (bit_index_d == '0) begin
            pin_levels_d[pl] = 1'b0;
          end
          priority if (!fpga_d) begin
            pin_levels_d[pc] = idle_lvl;
          end else if (is_read_d) begin
            pin_levels_d[pc] = 1'b0;
          end else if (bit_index_d != '0) begin
            pin_levels_d[pc] = 1'b1;
          end else begin
          end
        end
        PH_HIGH: pin_levels_d[pc] = fpga_d ? is_read_d : !idle_lvl;
        PH_LOW, PH_SLOW: pin_levels_d[pc] = 1'b0;
        PH_SAMPLE: begin
          receive_byte_d   = {receive_byte_d[6:0], miso_level_i};
          pin_levels_d[pc] = 1'b1;
        end
        PH_CLOSE: begin
          priority if (!fpga_d) begin
            pin_levels_d[pc] = idle_lvl;
            pin_levels_d[pl] = 1'b1;
          end else if (length_held_d == '0) begin
            pin_levels_d[pl] = 1'b0;
          end else if (!is_read_d) begin
            pin_levels_d[pc] = 1'b1;
          end else begin
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_ticks_q  <= 8'd1;
      phase_q        <= PH_IDLE;
      bit_index_q    <= '0;
      delay_count_q  <= 8'd0;
      shift_word_q   <= '0;
      receive_byte_q <= 8'd0;
      active_port_q  <= PORT_CTRL;
      is_read_q      <= 1'b0;
      length_held_q  <= '0;
      pin_levels_q   <= PIN_RESET;
      out_valid_q    <= 1'b0;
    end else begin
      if (delay_ticks_we_i) begin
        delay_ticks_q <= delay_ticks_i;
      end
      phase_q        <= phase_d;
      bit_index_q    <= bit_index_d;
      delay_count_q  <= delay_count_d;
      shift_word_q   <= shift_word_d;
      receive_byte_q <= receive_byte_d;
      active_port_q  <= active_port_d;
      is_read_q      <= is_read_d;
      length_held_q  <= length_held_d;
      pin_levels_q   <= pin_levels_d;
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload; loaded only when an item is accepted.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_pins_q <= pin_levels_d;
      out_busy_q <= (phase_d != PH_IDLE);
      out_done_q <= done_c;
      out_err_q  <= err_c;
      out_rb_q   <= rb_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ctrl_pins_o = out_pins_q[10:8];
  assign conv_pins_o = out_pins_q[7:5];
  assign fpga_pins_o = out_pins_q[4:0];
  assign busy_res_o  = out_busy_q;
  assign done_res_o  = out_done_q;
  assign error_o     = out_err_q;
  assign read_byte_o = out_rb_q;

  // A running transfer always has a delay pending.
  `SPI_ASSERT(a_delay_loaded, clk_i, rst_ni, (phase_q == PH_IDLE) || (delay_count_q != 8'd0), "busy with no delay pending")
  // The bit index never runs past the held length.
  `SPI_ASSERT(a_index_bound, clk_i, rst_ni, bit_index_q <= length_held_q, "bit index beyond length")
  // A finished transfer reports not busy, and a rejected start never finishes one.
  `SPI_ASSERT(a_done_idle, clk_i, rst_ni, !(out_valid_q && out_done_q) || (!out_busy_q && !out_err_q), "done while busy or in error")
  // A received byte appears only with done.
  `SPI_ASSERT(a_byte_with_done, clk_i, rst_ni, !(out_valid_q && !out_done_q) || (out_rb_q == 8'd0), "read byte without done")

endmodule

// File: tb/multi_port_spi_master_sequencer_tb.sv
`timescale 1ns / 100ps

module multi_port_spi_master_sequencer_tb
  import mpspi_pkg::*;
();

  // One result item as the block presents it, field by field.
  typedef struct packed {
    logic [2:0] ctrl;
    logic [2:0] conv;
    logic [4:0] fpga;
    logic       busy;
    logic       done;
    logic       err;
    logic [7:0] rx;
  } pin_result_t;

  // Pin positions of clock, latch enable and data for each line set, packed
  // four bits per port with the control port in the lowest nibble.
  localparam logic [15:0] CLK_AT  = {4'd3, 4'd4, 4'd7, 4'd10};
  localparam logic [15:0] LE_AT   = {4'd1, 4'd2, 4'd6, 4'd9};
  localparam logic [15:0] DATA_AT = {4'd0, 4'd0, 4'd5, 4'd8};
  localparam int unsigned LONGEST = 32;

  // Every input of the block starts at a known value.
  logic        clk_i;
  logic        rst_ni           = 1'b0;
  logic        delay_ticks_we_i = 1'b0;
  logic [7:0]  delay_ticks_i    = 8'd0;
  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic [1:0]  req_type_i       = REQ_TICK;
  logic [1:0]  port_i           = PORT_CTRL;
  logic [31:0] tx_word_i        = 32'd0;
  logic [7:0]  bit_count_i      = 8'd0;
  logic        miso_level_i     = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i      = 1'b0;
  logic [2:0]  ctrl_pins_o;
  logic [2:0]  conv_pins_o;
  logic [4:0]  fpga_pins_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic        error_o;
  logic [7:0]  read_byte_o;

  // Idle percentages for the two sides, and the length of a forced receiver
  // hold-off still to run.
  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  int unsigned rx_hold_left = 0;
  int unsigned items_sent   = 0;
  int unsigned mismatch_count = 0;

  // Results the block owes us, oldest first.
  pin_result_t pending_results[$];

  // Our own copy of the sequencer state and of the delay register.
  logic [7:0]        delay_reg = 8'd1;
  phase_e            sq_phase  = PH_IDLE;
  logic [5:0]        sq_bit    = '0;
  logic [7:0]        sq_wait   = '0;
  logic [31:0]       sq_word   = '0;
  logic [7:0]        sq_rx     = '0;
  port_e             sq_port   = PORT_CTRL;
  logic              sq_read   = 1'b0;
  logic [5:0]        sq_len    = '0;
  logic [PIN_W-1:0]  sq_pins   = PIN_RESET;

  multi_port_spi_master_sequencer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .delay_ticks_we_i(delay_ticks_we_i),
    .delay_ticks_i   (delay_ticks_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .port_i          (port_i),
    .tx_word_i       (tx_word_i),
    .bit_count_i     (bit_count_i),
    .miso_level_i    (miso_level_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .ctrl_pins_o     (ctrl_pins_o),
    .conv_pins_o     (conv_pins_o),
    .fpga_pins_o     (fpga_pins_o),
    .busy_res_o      (busy_res_o),
    .done_res_o      (done_res_o),
    .error_o         (error_o),
    .read_byte_o     (read_byte_o)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The run is cut off here if the handshakes ever stop moving.
  initial begin : watchdog
    #8_000_000;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequencer prediction
  // ---------------------------------------------------------------------------

  function automatic logic [3:0] pin_at(logic [15:0] pos_map, port_e p);
    return pos_map[int'(p) * 4 +: 4];
  endfunction

  function automatic void drive_pin(logic [3:0] pos, logic v);
    sq_pins[pos] = v;
  endfunction

  function automatic void drive_clk(logic v);
    drive_pin(pin_at(CLK_AT, sq_port), v);
  endfunction

  function automatic void drive_le(logic v);
    drive_pin(pin_at(LE_AT, sq_port), v);
  endfunction

  // Applies the pin group that belongs to the phase just entered.
  function automatic void apply_pin_group(logic miso);
    logic       fpga;
    logic       idle_clk;
    logic [5:0] pos;
    fpga     = sq_port[1];
    idle_clk = (sq_port == PORT_CONV);
    case (sq_phase)
      PH_OPEN: drive_le(1'b1);
      PH_PRE1, PH_PRE3, PH_TAIL1, PH_TAIL3: drive_clk(1'b1);
      PH_PRE2, PH_PRE4, PH_TAIL2, PH_TAIL4: drive_clk(1'b0);
      PH_SETUP: begin
        pos = sq_len - 6'd1 - sq_bit;
        drive_pin(pin_at(DATA_AT, sq_port), sq_word[pos[4:0]]);
        if (sq_bit == 6'd0) drive_le(1'b0);
        if (!fpga) drive_clk(idle_clk);
        else if (sq_read) drive_clk(1'b0);
        else if (sq_bit != 6'd0) drive_clk(1'b1);
      end
      PH_HIGH: begin
        if (!fpga) drive_clk(~idle_clk);
        else drive_clk(sq_read);
      end
      PH_LOW, PH_SLOW: drive_clk(1'b0);
      PH_SAMPLE: begin
        sq_rx = {sq_rx[6:0], miso};
        drive_clk(1'b1);
      end
      PH_CLOSE: begin
        if (!fpga) begin
          drive_clk(idle_clk);
          drive_le(1'b1);
        end else if (sq_len == 6'd0) begin
          drive_le(1'b0);
        end else if (!sq_read) begin
          drive_clk(1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  // Works out the phase that follows the current one; counts bits as it goes.
  function automatic phase_e next_pin_phase();
    logic fpga;
    fpga = sq_port[1];
    case (sq_phase)
      PH_OPEN: begin
        if (fpga) return PH_PRE1;
        return (sq_len != 6'd0) ? PH_SETUP : PH_CLOSE;
      end
      PH_PRE1: return PH_PRE2;
      PH_PRE2: return PH_PRE3;
      PH_PRE3: return PH_PRE4;
      PH_PRE4: return (sq_len != 6'd0) ? PH_SETUP : PH_CLOSE;
      PH_SETUP: return PH_HIGH;
      PH_HIGH: begin
        if (fpga && sq_read) return PH_LOW;
        sq_bit++;
        return (sq_bit < sq_len) ? PH_SETUP : PH_CLOSE;
      end
      PH_LOW: begin
        sq_bit++;
        if (sq_bit >= sq_len) return PH_CLOSE;
        return (sq_bit < READ_CMD_BITS) ? PH_SETUP : PH_SAMPLE;
      end
      PH_SAMPLE: return PH_SLOW;
      PH_SLOW: begin
        sq_bit++;
        return (sq_bit < sq_len) ? PH_SAMPLE : PH_CLOSE;
      end
      PH_CLOSE: return fpga ? PH_TAIL1 : PH_IDLE;
      PH_TAIL1: return PH_TAIL2;
      PH_TAIL2: return PH_TAIL3;
      PH_TAIL3: return PH_TAIL4;
      default:  return PH_IDLE;
    endcase
  endfunction

  // Advances our copy of the sequencer by one accepted item and returns the
  // result item the block must produce for it.
  function automatic pin_result_t predict_sequencer_step(req_e req, port_e port,
                                                          logic [31:0] word,
                                                          logic [7:0] count,
                                                          logic miso);
    pin_result_t r;
    phase_e      np;
    logic [7:0]  unit_ticks;
    r = '0;
    // A zero delay register behaves like a delay of one tick.
    unit_ticks = (delay_reg == 8'd0) ? 8'd1 : delay_reg;
    if (req == REQ_TICK) begin
      if (sq_phase != PH_IDLE) begin
        if (sq_wait > 8'd1) begin
          sq_wait--;
        end else begin
          np = next_pin_phase();
          sq_phase = np;
          if (np == PH_IDLE) begin
            r.done  = 1'b1;
            r.rx    = sq_read ? sq_rx : 8'd0;
            sq_wait = 8'd0;
          end else begin
            apply_pin_group(miso);
            sq_wait = unit_ticks;
          end
        end
      end
    end else if (req == REQ_WRITE || req == REQ_READ) begin
      // Too long, read on a port without a return line, or already running.
      if (sq_phase != PH_IDLE || count > LONGEST || (req == REQ_READ && !port[1])) begin
        r.err = 1'b1;
      end else begin
        sq_port  = port;
        sq_read  = (req == REQ_READ);
        sq_len   = count[5:0];
        sq_word  = word;
        sq_bit   = '0;
        sq_rx    = '0;
        sq_phase = PH_OPEN;
        apply_pin_group(miso);
        sq_wait  = unit_ticks;
      end
    end
    r.ctrl = sq_pins[10:8];
    r.conv = sq_pins[7:5];
    r.fpga = sq_pins[4:0];
    r.busy = (sq_phase != PH_IDLE);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving the block
  // ---------------------------------------------------------------------------

  // Offers one item, waits for it to be taken and files its expected result.
  // Valid stays high after acceptance so that back-to-back items need no
  // second assignment in one step; whoever stops sending lowers it.
  task automatic send_item(req_e req, port_e port, logic [31:0] word,
                           logic [7:0] count, logic miso);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    port_i       <= port;
    tx_word_i    <= word;
    bit_count_i  <= count;
    miso_level_i <= miso;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(predict_sequencer_step(req, port, word, count, miso));
    if (req != REQ_NONE) items_sent++;
  endtask

  // Any request code, any port, any length: mostly rejected or ignored.
  task automatic send_noise_item();
    send_item(req_e'($urandom_range(0, 3)), port_e'($urandom_range(0, 3)),
              $urandom(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Ticks the running transfer out to its end, with random line levels on
  // every tick and, now and then, an item that is rejected or ignored.
  task automatic finish_transfer(int unsigned noise_pct);
    while (sq_phase != PH_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) send_noise_item();
      else send_item(REQ_TICK, port_e'($urandom_range(0, 3)), $urandom(),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_transfer(req_e req, port_e port, logic [31:0] word,
                              logic [7:0] count, int unsigned noise_pct);
    send_item(req, port, word, count, 1'($urandom_range(0, 1)));
    finish_transfer(noise_pct);
  endtask

  // Stops sending and waits until every owed result has come back. Each item
  // gives exactly one result, so a short tail after the last one is enough.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // The delay register is only written with no transfer running.
  task automatic set_delay_units(logic [7:0] units);
    wait_idle();
    delay_ticks_we_i <= 1'b1;
    delay_ticks_i    <= units;
    @(posedge clk_i);
    delay_ticks_we_i <= 1'b0;
    delay_reg = units;
  endtask

  // The receiver drops ready at random; a forced hold-off overrides that for
  // a counted number of cycles.
  always @(posedge clk_i) begin
    if (rx_hold_left != 0) begin
      out_ready_i  <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  task automatic compare_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Every result taken from the block is matched against the oldest one owed.
  always @(posedge clk_i) begin : check_results
    pin_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item pending", 0, 0);
      end else begin
        want = pending_results.pop_front();
        compare_field("ctrl_pins", 32'(ctrl_pins_o), 32'(want.ctrl));
        compare_field("conv_pins", 32'(conv_pins_o), 32'(want.conv));
        compare_field("fpga_pins", 32'(fpga_pins_o), 32'(want.fpga));
        compare_field("busy_res", 32'(busy_res_o), 32'(want.busy));
        compare_field("done_res", 32'(done_res_o), 32'(want.done));
        compare_field("error", 32'(error_o), 32'(want.err));
        compare_field("read_byte", 32'(read_byte_o), 32'(want.rx));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Full transfers on every line set: longest and empty words, all-ones and
  // all-zeros data, reads that stop inside the command bits, at its edge and
  // deep into the sampling bits.
  task automatic test_transfers_per_port();
    send_gap_pct = 10;
    recv_gap_pct = 10;
    // Ticks and an unused request code while idle change nothing.
    send_item(REQ_TICK, PORT_FPGA2, 32'hffff_ffff, 8'hff, 1'b1);
    send_item(REQ_NONE, PORT_FPGA2, 32'hffff_ffff, 8'hff, 1'b1);
    run_transfer(REQ_WRITE, PORT_CTRL, 32'hffff_ffff, 8'd32, 0);
    run_transfer(REQ_WRITE, PORT_CONV, 32'ha5a5_5a5a, 8'd32, 0);
    run_transfer(REQ_WRITE, PORT_CTRL, 32'h0000_0000, 8'd0, 0);
    run_transfer(REQ_WRITE, PORT_CONV, 32'h0000_0000, 8'd0, 0);
    run_transfer(REQ_WRITE, PORT_FPGA1, 32'hffff_ffff, 8'd0, 0);
    run_transfer(REQ_WRITE, PORT_FPGA2, 32'h0000_0001, 8'd1, 0);
    run_transfer(REQ_WRITE, PORT_FPGA1, 32'h8000_0000, 8'd32, 0);
    run_transfer(REQ_READ, PORT_FPGA1, 32'hc300_0000, 8'd32, 0);
    run_transfer(REQ_READ, PORT_FPGA2, 32'h0000_00a5, 8'd8, 0);
    run_transfer(REQ_READ, PORT_FPGA1, 32'h0000_0015, 8'd5, 0);
    run_transfer(REQ_READ, PORT_FPGA2, 32'h0000_0fff, 8'd12, 0);
    run_transfer(REQ_READ, PORT_FPGA2, 32'h0000_0000, 8'd0, 0);
  endtask

  // Starts that must be refused, and items that arrive mid-transfer.
  task automatic test_rejected_starts();
    send_item(REQ_WRITE, PORT_CTRL, 32'h1234_5678, 8'd33, 1'b0);
    send_item(REQ_WRITE, PORT_FPGA1, 32'h1234_5678, 8'd255, 1'b1);
    send_item(REQ_READ, PORT_CTRL, 32'h0000_00ff, 8'd8, 1'b1);
    send_item(REQ_READ, PORT_CONV, 32'h0000_00ff, 8'd8, 1'b0);
    send_item(REQ_READ, PORT_FPGA2, 32'h0000_00ff, 8'd40, 1'b0);
    // A start while busy is refused and the running transfer does not move on
    // that item; an unused request code in the middle is simply skipped.
    send_item(REQ_WRITE, PORT_CONV, 32'h0000_000b, 8'd4, 1'b0);
    send_item(REQ_TICK, PORT_CTRL, 32'd0, 8'd0, 1'b0);
    send_item(REQ_WRITE, PORT_CTRL, 32'd0, 8'd0, 1'b0);
    send_item(REQ_READ, PORT_FPGA1, 32'd0, 8'd8, 1'b1);
    send_item(REQ_NONE, PORT_FPGA1, 32'hffff_ffff, 8'd8, 1'b1);
    finish_transfer(0);
  endtask

  // Delay register at zero (acts as one), its top value and a value between.
  task automatic test_delay_extremes();
    set_delay_units(8'd0);
    run_transfer(REQ_WRITE, PORT_CONV, 32'h0000_0005, 8'd3, 0);
    run_transfer(REQ_READ, PORT_FPGA1, 32'h0000_03a5, 8'd10, 0);
    // The top value only with an empty word keeps the tick count sensible.
    set_delay_units(8'd255);
    run_transfer(REQ_WRITE, PORT_CTRL, 32'hffff_ffff, 8'd0, 2);
    set_delay_units(8'd2);
    run_transfer(REQ_READ, PORT_FPGA2, 32'h0000_0155, 8'd10, 5);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // ticks back to back, so the result stage fills and input ready drops.
  task automatic test_backpressure();
    set_delay_units(8'd1);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    send_item(REQ_WRITE, PORT_FPGA1, $urandom(), 8'd32, 1'b0);
    rx_hold_left <= 300;
    finish_transfer(0);
    send_item(REQ_READ, PORT_FPGA2, $urandom(), 8'd20, 1'b1);
    rx_hold_left <= 150;
    finish_transfer(3);
  endtask

  // Mostly well-formed transfers with random content, the rest random noise
  // items whose effect, if any, is then ticked out to its end.
  task automatic random_burst(int unsigned n_items);
    int unsigned first;
    port_e       port;
    req_e        req;
    logic [7:0]  count;
    first = items_sent;
    while (items_sent - first < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        port  = port_e'($urandom_range(0, 3));
        req   = (port[1] && $urandom_range(0, 1)) ? REQ_READ : REQ_WRITE;
        count = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 12))
                                             : 8'($urandom_range(13, 32));
        if ($urandom_range(0, 99) < 5) count = 8'($urandom_range(33, 255));
        run_transfer(req, port, $urandom(), count, 6);
      end else begin
        send_noise_item();
        finish_transfer(6);
      end
    end
  endtask

  // Three idle patterns: slow receiver, slow sender, then no idling at all.
  task automatic test_random_traffic();
    set_delay_units(8'd1);
    send_gap_pct = 22;
    recv_gap_pct = 81;
    random_burst(220);
    set_delay_units(8'd3);
    send_gap_pct = 81;
    recv_gap_pct = 22;
    random_burst(220);
    set_delay_units(8'd2);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    random_burst(220);
  endtask

  initial begin : main_sequence
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_transfers_per_port();
    test_rejected_starts();
    test_delay_extremes();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/mpspi_pkg.sv
rtl/multi_port_spi_master_sequencer.sv
tb/multi_port_spi_master_sequencer_tb.sv
